[rtl/mst_pkg.sv]
`timescale 1ns / 1ps

package mst_pkg;

    // Operation codes carried by each input word
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PIN   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    localparam logic [6:0] MAX_MINUTES = 7'd99;
    localparam logic [5:0] MAX_SECONDS = 6'd59;
    localparam int         COLON_BIT   = 7;

    // Segment patterns for digits 0..9, bit 0 = segment a
    localparam logic [7:0] SEG_PATTERN [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
        8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // One result word as held in the output stages
    typedef struct packed {
        logic [7:0] seg_digit0;
        logic [7:0] seg_digit1;
        logic [7:0] seg_digit2;
        logic [7:0] seg_digit3;
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic       time_up;
        logic [6:0] pinned_min;
        logic [5:0] pinned_sec;
    } result_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] pattern;
        if (digit <= 4'd9)
        begin
            pattern = SEG_PATTERN[digit];
        end
        else
        begin
            pattern = SEG_PATTERN[0];
        end
        return pattern;
    endfunction

    // Tens digit of a value below 100: independent threshold compares
    function automatic logic [3:0] tens_of(input logic [6:0] value);
        logic [3:0] tens;
        tens = 4'd0;
        for (int d = 1; d <= 9; d++)
        begin
            if (value >= 7'(d * 10))
            begin
                tens = 4'(d);
            end
        end
        return tens;
    endfunction

endpackage

[rtl/mst_disp.sv]
`timescale 1ns / 1ps

// Split minutes and seconds into decimal digits and map them to segments.
module mst_disp (
    input  logic [6:0] minutes,
    input  logic [5:0] seconds,
    input  logic       colon_on,
    output logic [7:0] seg_digit0,
    output logic [7:0] seg_digit1,
    output logic [7:0] seg_digit2,
    output logic [7:0] seg_digit3
);

    logic [3:0] min_tens;
    logic [3:0] min_units;
    logic [3:0] sec_tens;
    logic [3:0] sec_units;
    logic [6:0] min_tens_x10;
    logic [6:0] sec_tens_x10;

    always_comb
    begin
        min_tens     = mst_pkg::tens_of(minutes);
        sec_tens     = mst_pkg::tens_of({1'b0, seconds});
        min_tens_x10 = {3'b000, min_tens} * 7'd10;
        sec_tens_x10 = {3'b000, sec_tens} * 7'd10;
        min_units    = 4'(minutes - min_tens_x10);
        sec_units    = 4'({1'b0, seconds} - sec_tens_x10);

        seg_digit0 = mst_pkg::seg_of(min_tens);
        seg_digit1 = mst_pkg::seg_of(min_units);
        seg_digit1[mst_pkg::COLON_BIT] = colon_on;
        seg_digit2 = mst_pkg::seg_of(sec_tens);
        seg_digit3 = mst_pkg::seg_of(sec_units);
    end

endmodule

[rtl/minute_second_timer_seven_segment.sv]
`timescale 1ns / 1ps

// Minutes:seconds timer, 00:00 to 99:59, with a four-digit segment image.
//
// Input channel (in_valid / in_stall): one word per operation - tick one
// second, pin the current time, clear time and pinned time, or load a time
// (load fields clamp to 99 minutes and 59 seconds). A word is taken on a
// rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): exactly one result word per input
// word, in order: four segment bytes (colon in bit 7 of seg_digit1), the
// time after the operation, time_up (down tick found 00:00) and the pinned
// time.
// Configuration: cfg_we writes cfg_wdata into count_up (1 = ticks count up
// and wrap 99:59 to 00:00, 0 = count down and stop at 00:00). Write it only
// while the block is idle.
// A taken word's result is registered in the output register, or in the skid
// register if the output stalls; one word per cycle while in_stall is low. The
// next time is combinational, so the time loop closes in a single register.
// A two-entry output stage (output register plus skid register) lets a word
// be taken while a result waits; in_stall rises only once both are full.
// Reset clears time, pinned time, count_up and both output valid flags.

module minute_second_timer_seven_segment (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic       colon_on,
    input  logic [6:0] load_minutes,
    input  logic [5:0] load_seconds,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] seg_digit0,
    output logic [7:0] seg_digit1,
    output logic [7:0] seg_digit2,
    output logic [7:0] seg_digit3,
    output logic [6:0] minutes_now,
    output logic [5:0] seconds_now,
    output logic       time_up,
    output logic [6:0] pinned_min_out,
    output logic [5:0] pinned_sec_out
);

    logic       count_up_reg;
    logic [6:0] minutes_reg;
    logic [6:0] minutes_next;
    logic [5:0] seconds_reg;
    logic [5:0] seconds_next;
    logic [6:0] pin_min_reg;
    logic [6:0] pin_min_next;
    logic [5:0] pin_sec_reg;
    logic [5:0] pin_sec_next;
    logic       time_up_next;

    mst_pkg::op_t     op;
    mst_pkg::result_t new_result;
    mst_pkg::result_t out_reg;
    mst_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             accept;
    logic             out_free;

    assign accept   = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    // Output slot can take a word when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // Next time from the current state and the incoming word
    always_comb
    begin
        op           = mst_pkg::op_t'(operation);
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        pin_min_next = pin_min_reg;
        pin_sec_next = pin_sec_reg;
        time_up_next = 1'b0;
        unique case (op)
            mst_pkg::OP_TICK:
            begin
                if (count_up_reg)
                begin
                    if (seconds_reg < mst_pkg::MAX_SECONDS)
                    begin
                        seconds_next = seconds_reg + 6'd1;
                    end
                    else
                    begin
                        // wrap seconds, then minutes; 99:59 goes straight to 00:00
                        seconds_next = 6'd0;
                        if (minutes_reg < mst_pkg::MAX_MINUTES)
                        begin
                            minutes_next = minutes_reg + 7'd1;
                        end
                        else
                        begin
                            minutes_next = 7'd0;
                        end
                    end
                end
                else
                begin
                    if (seconds_reg != 6'd0)
                    begin
                        seconds_next = seconds_reg - 6'd1;
                    end
                    else if (minutes_reg != 7'd0)
                    begin
                        minutes_next = minutes_reg - 7'd1;
                        seconds_next = mst_pkg::MAX_SECONDS;
                    end
                    else
                    begin
                        // hold at 00:00 and flag it
                        time_up_next = 1'b1;
                    end
                end
            end
            mst_pkg::OP_PIN:
            begin
                pin_min_next = minutes_reg;
                pin_sec_next = seconds_reg;
            end
            mst_pkg::OP_CLEAR:
            begin
                minutes_next = 7'd0;
                seconds_next = 6'd0;
                pin_min_next = 7'd0;
                pin_sec_next = 6'd0;
            end
            mst_pkg::OP_LOAD:
            begin
                minutes_next = (load_minutes > mst_pkg::MAX_MINUTES) ?
                               mst_pkg::MAX_MINUTES : load_minutes;
                seconds_next = (load_seconds > mst_pkg::MAX_SECONDS) ?
                               mst_pkg::MAX_SECONDS : load_seconds;
            end
            default:
            begin
                minutes_next = minutes_reg;
            end
        endcase
    end

    mst_disp u_disp (
        .minutes    (minutes_next),
        .seconds    (seconds_next),
        .colon_on   (colon_on),
        .seg_digit0 (new_result.seg_digit0),
        .seg_digit1 (new_result.seg_digit1),
        .seg_digit2 (new_result.seg_digit2),
        .seg_digit3 (new_result.seg_digit3)
    );

    assign new_result.minutes    = minutes_next;
    assign new_result.seconds    = seconds_next;
    assign new_result.time_up    = time_up_next;
    assign new_result.pinned_min = pin_min_next;
    assign new_result.pinned_sec = pin_sec_next;

    // Timer state and the count direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_up_reg <= 1'b0;
            minutes_reg  <= 7'd0;
            seconds_reg  <= 6'd0;
            pin_min_reg  <= 7'd0;
            pin_sec_reg  <= 6'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_up_reg <= cfg_wdata;
            end
            if (accept)
            begin
                minutes_reg <= minutes_next;
                seconds_reg <= seconds_next;
                pin_min_reg <= pin_min_next;
                pin_sec_reg <= pin_sec_next;
            end
        end
    end

    // Output register and skid register valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid drains first; no new word is taken while it is full
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of both stages; no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= new_result;
            end
        end
        else if (accept)
        begin
            skid_reg <= new_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign seg_digit0     = out_reg.seg_digit0;
    assign seg_digit1     = out_reg.seg_digit1;
    assign seg_digit2     = out_reg.seg_digit2;
    assign seg_digit3     = out_reg.seg_digit3;
    assign minutes_now    = out_reg.minutes;
    assign seconds_now    = out_reg.seconds;
    assign time_up        = out_reg.time_up;
    assign pinned_min_out = out_reg.pinned_min;
    assign pinned_sec_out = out_reg.pinned_sec;

endmodule

[rtl/mst_checker.sv]
`timescale 1ns / 1ps

module mst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] minutes_now,
    input logic [5:0] seconds_now,
    input logic       time_up,
    input logic [6:0] pinned_min_out,
    input logic [5:0] pinned_sec_out
);

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Input backs up only when a result is already waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // Time up only reports a timer sitting at 00:00
    a_time_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && time_up |-> minutes_now == 7'd0 && seconds_now == 6'd0)
        else $error("time_up with nonzero time");

    // Reported times stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> minutes_now <= 7'd99 && seconds_now <= 6'd59 &&
                      pinned_min_out <= 7'd99 && pinned_sec_out <= 6'd59)
        else $error("time out of range");

endmodule

bind minute_second_timer_seven_segment mst_checker u_mst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .minutes_now    (minutes_now),
    .seconds_now    (seconds_now),
    .time_up        (time_up),
    .pinned_min_out (pinned_min_out),
    .pinned_sec_out (pinned_sec_out)
);

[test/tb_minute_second_timer_seven_segment.sv]
`timescale 1ns / 1ps

module tb_minute_second_timer_seven_segment;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_WORDS  = 170;   // per run segment, six segments
    localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
    localparam int TAIL_CYCLES   = 4;

    // One operation word as queued for the driver
    typedef struct {
        mst_pkg::op_t op;
        logic         colon;
        logic [6:0]   load_min;
        logic [5:0]   load_sec;
    } timer_word_t;

    // One display word as the block should return it
    typedef struct packed {
        logic [7:0] digit0;
        logic [7:0] digit1;
        logic [7:0] digit2;
        logic [7:0] digit3;
        logic [6:0] mins;
        logic [5:0] secs;
        logic       expired;
        logic [6:0] pin_min;
        logic [5:0] pin_sec;
    } display_word_t;

    // Segment patterns, bit 0 = segment a
    localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
        8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] operation;
    logic       colon_on;
    logic [6:0] load_minutes;
    logic [5:0] load_seconds;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] seg_digit0;
    logic [7:0] seg_digit1;
    logic [7:0] seg_digit2;
    logic [7:0] seg_digit3;
    logic [6:0] minutes_now;
    logic [5:0] seconds_now;
    logic       time_up;
    logic [6:0] pinned_min_out;
    logic [5:0] pinned_sec_out;

    // Words waiting to be sent; the head leaves only when the block takes it
    timer_word_t   pending_ops[$];
    // Display words predicted for accepted operations, oldest first
    display_word_t expected_displays[$];

    // Predicted timer state and the count direction register
    logic [6:0] clock_min;
    logic [5:0] clock_sec;
    logic [6:0] pinned_min;
    logic [5:0] pinned_sec;
    logic       counting_up;

    int   mismatches;
    int   quiet_cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic word_taken;
    logic send_gap;
    display_word_t seen;
    display_word_t want;

    minute_second_timer_seven_segment dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .colon_on       (colon_on),
        .load_minutes   (load_minutes),
        .load_seconds   (load_seconds),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .seg_digit0     (seg_digit0),
        .seg_digit1     (seg_digit1),
        .seg_digit2     (seg_digit2),
        .seg_digit3     (seg_digit3),
        .minutes_now    (minutes_now),
        .seconds_now    (seconds_now),
        .time_up        (time_up),
        .pinned_min_out (pinned_min_out),
        .pinned_sec_out (pinned_sec_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Apply one operation to the predicted state and build the display word.
    function automatic display_word_t advance_timer(input mst_pkg::op_t op,
                                                    input logic colon,
                                                    input logic [6:0] lm,
                                                    input logic [5:0] ls);
        display_word_t r;
        r = '0;
        case (op)
            mst_pkg::OP_TICK:
            begin
                if (counting_up)
                begin
                    // Up: carry seconds into minutes, wrap 99:59 straight to 00:00
                    if (clock_sec < 6'd59)
                    begin
                        clock_sec = clock_sec + 6'd1;
                    end
                    else
                    begin
                        clock_sec = 6'd0;
                        clock_min = (clock_min < 7'd99) ? clock_min + 7'd1 : 7'd0;
                    end
                end
                else if (clock_sec != 6'd0)
                begin
                    clock_sec = clock_sec - 6'd1;
                end
                else if (clock_min != 7'd0)
                begin
                    // Borrow a minute
                    clock_min = clock_min - 7'd1;
                    clock_sec = 6'd59;
                end
                else
                begin
                    // Down tick at 00:00: hold the time and flag expiry
                    r.expired = 1'b1;
                end
            end
            mst_pkg::OP_PIN:
            begin
                pinned_min = clock_min;
                pinned_sec = clock_sec;
            end
            mst_pkg::OP_CLEAR:
            begin
                clock_min  = 7'd0;
                clock_sec  = 6'd0;
                pinned_min = 7'd0;
                pinned_sec = 6'd0;
            end
            default:
            begin
                // Load: clamp to 99 minutes and 59 seconds
                clock_min = (lm > 7'd99) ? 7'd99 : lm;
                clock_sec = (ls > 6'd59) ? 6'd59 : ls;
            end
        endcase
        r.digit0  = DIGIT_SEGMENTS[4'(clock_min / 7'd10)];
        r.digit1  = {colon, DIGIT_SEGMENTS[4'(clock_min % 7'd10)][6:0]};
        r.digit2  = DIGIT_SEGMENTS[4'(clock_sec / 6'd10)];
        r.digit3  = DIGIT_SEGMENTS[4'(clock_sec % 6'd10)];
        r.mins    = clock_min;
        r.secs    = clock_sec;
        r.pin_min = pinned_min;
        r.pin_sec = pinned_sec;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $time, name, exp_val, exp_val, act_val, act_val);
        end
    endtask

    // Monitor: track the register, check every result taken, predict every word taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clock_min   = 7'd0;
            clock_sec   = 6'd0;
            pinned_min  = 7'd0;
            pinned_sec  = 6'd0;
            counting_up = 1'b0;
            word_taken <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                counting_up = cfg_wdata;
            end
            if (out_valid && !out_stall)
            begin
                seen = {seg_digit0, seg_digit1, seg_digit2, seg_digit3, minutes_now,
                        seconds_now, time_up, pinned_min_out, pinned_sec_out};
                if (expected_displays.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with no word pending, expected none, got 0x%0h",
                             $time, seen);
                end
                else
                begin
                    want = expected_displays.pop_front();
                    check_field("seg_digit0", want.digit0, seen.digit0);
                    check_field("seg_digit1", want.digit1, seen.digit1);
                    check_field("seg_digit2", want.digit2, seen.digit2);
                    check_field("seg_digit3", want.digit3, seen.digit3);
                    check_field("minutes_now", want.mins, seen.mins);
                    check_field("seconds_now", want.secs, seen.secs);
                    check_field("time_up", want.expired, seen.expired);
                    check_field("pinned_min_out", want.pin_min, seen.pin_min);
                    check_field("pinned_sec_out", want.pin_sec, seen.pin_sec);
                end
            end
            if (in_valid && !in_stall)
            begin
                // Predict from the port values, then retire the word from the send queue
                expected_displays.push_back(advance_timer(mst_pkg::op_t'(operation),
                                                          colon_on, load_minutes,
                                                          load_seconds));
                void'(pending_ops.pop_front());
            end
            word_taken <= in_valid && !in_stall;
        end
    end

    // Driver: hold a stalled word, else present the queue head or idle; set out_stall.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            send_gap = (send_idle_pct != 0) && ($urandom_range(0, 99) < send_idle_pct);
            if (!send_gap && pending_ops.size() != 0)
            begin
                in_valid     <= 1'b1;
                operation    <= pending_ops[0].op;
                colon_on     <= pending_ops[0].colon;
                load_minutes <= pending_ops[0].load_min;
                load_seconds <= pending_ops[0].load_sec;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_op(input mst_pkg::op_t op, input logic colon, input logic [6:0] lm,
                          input logic [5:0] ls);
        timer_word_t w;
        w.op       = op;
        w.colon    = colon;
        w.load_min = lm;
        w.load_sec = ls;
        pending_ops.push_back(w);
    endtask

    // Random word: mostly ticks; load fields are fully random or aimed at the
    // borders where the counter borrows, carries, wraps or expires.
    task automatic add_random_op();
        int           pick;
        int           aim;
        mst_pkg::op_t op;
        logic [6:0]   lm;
        logic [5:0]   ls;
        pick = $urandom_range(0, 99);
        aim  = $urandom_range(0, 3);
        if (pick < 60)
        begin
            op = mst_pkg::OP_TICK;
        end
        else if (pick < 72)
        begin
            op = mst_pkg::OP_PIN;
        end
        else if (pick < 76)
        begin
            op = mst_pkg::OP_CLEAR;
        end
        else
        begin
            op = mst_pkg::OP_LOAD;
        end
        case (aim)
            0:
            begin
                lm = 7'($urandom_range(0, 127));
                ls = 6'($urandom_range(0, 63));
            end
            1:
            begin
                lm = 7'($urandom_range(0, 1));
                ls = 6'($urandom_range(0, 3));
            end
            2:
            begin
                lm = 7'($urandom_range(98, 99));
                ls = 6'($urandom_range(56, 59));
            end
            default:
            begin
                lm = 7'($urandom_range(0, 99));
                ls = ($urandom_range(0, 1) != 0) ? 6'd59 : 6'd0;
            end
        endcase
        add_op(op, 1'($urandom_range(0, 1)), lm, ls);
    endtask

    // Wait until every word is sent and every result is back
    task automatic wait_for_drain();
        while (pending_ops.size() != 0 || expected_displays.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_count_up(input logic value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        in_valid       = 1'b0;
        operation      = mst_pkg::OP_TICK;
        colon_on       = 1'b0;
        load_minutes   = 7'd0;
        load_seconds   = 6'd0;
        out_stall      = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, counting down: expiry at 00:00, clamping, borrows
        write_count_up(1'b0);
        add_op(mst_pkg::OP_TICK, 1'b1, 7'd0, 6'd0);
        add_op(mst_pkg::OP_LOAD, 1'b0, 7'd127, 6'd63);
        add_op(mst_pkg::OP_LOAD, 1'b1, 7'd100, 6'd60);
        add_op(mst_pkg::OP_LOAD, 1'b0, 7'd99, 6'd59);
        add_op(mst_pkg::OP_PIN, 1'b1, 7'd0, 6'd0);
        add_op(mst_pkg::OP_TICK, 1'b0, 7'd127, 6'd63);
        add_op(mst_pkg::OP_LOAD, 1'b1, 7'd1, 6'd0);
        add_op(mst_pkg::OP_TICK, 1'b1, 7'd0, 6'd0);
        add_op(mst_pkg::OP_LOAD, 1'b0, 7'd0, 6'd1);
        add_op(mst_pkg::OP_TICK, 1'b0, 7'd0, 6'd0);
        add_op(mst_pkg::OP_TICK, 1'b1, 7'd0, 6'd0);
        add_op(mst_pkg::OP_TICK, 1'b0, 7'd0, 6'd0);
        add_op(mst_pkg::OP_CLEAR, 1'b1, 7'd127, 6'd63);
        wait_for_drain();

        // Directed, counting up: wrap at 99:59, carry into minutes, clear
        write_count_up(1'b1);
        add_op(mst_pkg::OP_LOAD, 1'b1, 7'd99, 6'd58);
        add_op(mst_pkg::OP_TICK, 1'b0, 7'd0, 6'd0);
        add_op(mst_pkg::OP_PIN, 1'b1, 7'd0, 6'd0);
        add_op(mst_pkg::OP_TICK, 1'b1, 7'd0, 6'd0);
        add_op(mst_pkg::OP_LOAD, 1'b0, 7'd9, 6'd59);
        add_op(mst_pkg::OP_TICK, 1'b1, 7'd0, 6'd0);
        add_op(mst_pkg::OP_PIN, 1'b0, 7'd0, 6'd0);
        add_op(mst_pkg::OP_CLEAR, 1'b0, 7'd0, 6'd0);
        add_op(mst_pkg::OP_TICK, 1'b1, 7'd0, 6'd0);
        wait_for_drain();

        // Random: three idling patterns, each run in both count directions
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct  = (mode == 0) ? 16 : (mode == 1) ? 68 : 0;
            recv_stall_pct = (mode == 0) ? 68 : (mode == 1) ? 16 : 0;
            for (int half = 0; half < 2; half++)
            begin
                write_count_up(1'(half) ^ (mode == 1));
                for (int n = 0; n < RANDOM_WORDS; n++)
                begin
                    add_random_op();
                end
                wait_for_drain();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
